@@ rtl/hsec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hsec_pkg;

  // Field widths
  localparam int DATA_W = 57;
  localparam int CW_W   = 63;
  localparam int SYN_W  = 6;
  localparam int LEN_W  = 6;
  localparam int CNT_W  = 3;

  // Largest data length in use; longer settings saturate here
  localparam int DATA_BITS = 57;

  // Data-length thresholds for the parity-bit count
  localparam int K_R6 = 26;
  localparam int K_R5 = 11;
  localparam int K_R4 = 4;
  localparam int K_R3 = 1;

  localparam logic [LEN_W-1:0] DATA_LENGTH_RESET = LEN_W'(8);

  typedef logic [CW_W-1:0]   cw_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [SYN_W-1:0]  syn_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Codeword length n = k + r from a raw data-length setting
  function automatic len_t codeword_len(input len_t value);
    len_t       k;
    logic [2:0] r;
    if (value == '0) begin
      k = LEN_W'(1);
    end else if (value > LEN_W'(DATA_BITS)) begin
      k = LEN_W'(DATA_BITS);
    end else begin
      k = value;
    end
    if (k > LEN_W'(K_R6)) begin
      r = 3'd6;
    end else if (k > LEN_W'(K_R5)) begin
      r = 3'd5;
    end else if (k > LEN_W'(K_R4)) begin
      r = 3'd4;
    end else if (k > LEN_W'(K_R3)) begin
      r = 3'd3;
    end else begin
      r = 3'd2;
    end
    return k + LEN_W'(r);
  endfunction

  function automatic bit is_pow2(input int p);
    return (p & (p - 1)) == 0;
  endfunction

  // Data bit that lands at non-power-of-two position p
  function automatic int data_index(input int p);
    return p - 1 - $clog2(p + 1);
  endfunction

  // Positions covered by parity group i
  function automatic cw_t group_mask(input int i);
    cw_t m;
    m = '0;
    for (int p = 1; p <= CW_W; p++) begin
      m[p-1] = ((p >> i) & 1) != 0;
    end
    return m;
  endfunction

  function automatic cnt_t popcount_syn(input syn_t s);
    cnt_t c;
    c = '0;
    for (int i = 0; i < SYN_W; i++) begin
      c = c + CNT_W'(s[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/hsec_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface hsec_req_if import hsec_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  mode;
  data_t data_word;
  cw_t   received_word;

  modport source (output valid, mode, data_word, received_word, input ready);
  modport sink   (input valid, mode, data_word, received_word, output ready);
endinterface

interface hsec_res_if import hsec_pkg::*; ();
  logic valid;
  logic ready;
  cw_t  codeword;
  syn_t syndrome;
  cnt_t failed_groups;
  logic bit_flipped;
  logic syndrome_out_of_range;

  modport source (output valid, codeword, syndrome, failed_groups, bit_flipped,
                  syndrome_out_of_range, input ready);
  modport sink   (input valid, codeword, syndrome, failed_groups, bit_flipped,
                  syndrome_out_of_range, output ready);
  modport mon    (input valid, ready, codeword, syndrome, failed_groups, bit_flipped,
                  syndrome_out_of_range);
endinterface

interface hsec_cfg_if import hsec_pkg::*; ();
  logic valid;
  logic ready;
  len_t data_length;

  modport source (output valid, data_length, input ready);
  modport sink   (input valid, data_length, output ready);
endinterface

`default_nettype wire

@@ rtl/hamming_sec_encode_correct_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                              Handshake
// req_i    in   mode, data_word[56:0], received_word[62:0]            valid/ready
// res_o    out  codeword[62:0], syndrome[5:0], failed_groups[2:0],    valid/ready
//               bit_flipped, syndrome_out_of_range
// cfg_i    in   data_length[5:0]                                     valid/ready
//
// One transaction per cycle sustained while res_o is ready; a req_i accept passes
// through an input register, then the syndrome XOR trees and the correction decode,
// then the result register, which drives res_o valid.
// Reset clears both valid flags and loads the codeword length for data length 8.
// A stalled res_o holds its result; req_i keeps accepting until both stages fill.
// cfg_i is always ready; the new length applies from the next cycle, so write it idle.

module hamming_sec_encode_correct_unit import hsec_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  hsec_req_if.sink    req_i,
  hsec_res_if.source  res_o,
  hsec_cfg_if.sink    cfg_i
);

  // Codeword length held directly; the clamp and parity count happen at write
  len_t n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= codeword_len(DATA_LENGTH_RESET);
    end else if (cfg_i.valid) begin
      n_q <= codeword_len(cfg_i.data_length);
    end
  end

  assign cfg_i.ready = 1'b1;

  // Input stage
  logic  s1_v_q, s1_v_d;
  logic  mode_q;
  data_t data_q;
  cw_t   recv_q;

  // Result stage
  logic  res_v_q, res_v_d;
  cw_t   cw_q;
  syn_t  syn_q;
  cnt_t  cnt_q;
  logic  flip_q;
  logic  oor_q;

  logic s2_ready;
  logic req_fire;

  assign s2_ready    = !res_v_q || res_o.ready;
  assign req_i.ready = !s1_v_q || s2_ready;
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    // drop the stage when it moves on, refill on a new transaction
    s1_v_d = s1_v_q && !s2_ready;
    if (req_fire) begin
      s1_v_d = 1'b1;
    end
    res_v_d = res_v_q;
    if (s2_ready) begin
      res_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      mode_q <= req_i.mode;
      data_q <= req_i.data_word;
      recv_q <= req_i.received_word;
    end
  end

  // Datapath: fixed position map, length mask, syndrome trees
  cw_t  placed;
  cw_t  len_mask;
  cw_t  base;
  cw_t  enc_word;
  cw_t  flip_dec;
  syn_t syn;

  for (genvar gp = 1; gp <= CW_W; gp++) begin : g_pos
    if (is_pow2(gp)) begin : g_par
      localparam int PI = $clog2(gp);
      assign placed[gp-1]   = 1'b0;
      assign enc_word[gp-1] = syn[PI];
    end else begin : g_dat
      localparam int DI = data_index(gp);
      assign placed[gp-1]   = data_q[DI];
      assign enc_word[gp-1] = base[gp-1];
    end
    assign len_mask[gp-1] = (LEN_W'(gp) <= n_q);
    assign flip_dec[gp-1] = (syn == SYN_W'(gp));
  end

  // Positions above n are cleared; data bits past the length land there
  assign base = (mode_q ? recv_q : placed) & len_mask;

  for (genvar gi = 0; gi < SYN_W; gi++) begin : g_syn
    localparam cw_t GM = group_mask(gi);
    assign syn[gi] = ^(base & GM);
  end

  logic syn_oor;
  logic syn_hit;
  cw_t  chk_word;

  assign syn_oor  = syn > n_q;
  assign syn_hit  = (syn != '0) && !syn_oor;
  assign chk_word = syn_hit ? (base ^ flip_dec) : base;

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      if (mode_q) begin
        cw_q   <= chk_word;
        syn_q  <= syn;
        cnt_q  <= popcount_syn(syn);
        flip_q <= syn_hit;
        oor_q  <= syn_oor;
      end else begin
        // encode: syndrome of the placed data becomes the parity bits
        cw_q   <= enc_word;
        syn_q  <= '0;
        cnt_q  <= '0;
        flip_q <= 1'b0;
        oor_q  <= 1'b0;
      end
    end
  end

  assign res_o.valid                 = res_v_q;
  assign res_o.codeword              = cw_q;
  assign res_o.syndrome              = syn_q;
  assign res_o.failed_groups         = cnt_q;
  assign res_o.bit_flipped           = flip_q;
  assign res_o.syndrome_out_of_range = oor_q;

endmodule

`default_nettype wire

@@ rtl/hsec_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hsec_chk import hsec_pkg::*; (
  input wire          clk_i,
  input wire          rst_ni,
  hsec_res_if.source  res_o
);

  // A result is either corrected or flagged, never both
  a_flip_xor_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.bit_flipped && res_o.syndrome_out_of_range))
    else $error("bit_flipped and syndrome_out_of_range both set");

  // Clean syndrome means no correction and no flag
  a_zero_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.syndrome == '0) |->
      (!res_o.bit_flipped && !res_o.syndrome_out_of_range && res_o.failed_groups == '0))
    else $error("zero syndrome with correction or failed groups");

  // Failed group count tracks the syndrome weight
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.failed_groups == CNT_W'($countones(res_o.syndrome))))
    else $error("failed_groups does not match syndrome");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=>
      (res_o.valid && $stable(res_o.codeword) && $stable(res_o.syndrome)))
    else $error("stalled result changed");

endmodule

bind hamming_sec_encode_correct_unit hsec_chk u_hsec_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .res_o  (res_o)
);

`default_nettype wire
